[rtl/core/ilt_pkg.sv]
package ilt_pkg;

	localparam int ILT_DEPTH_DEF = 64;
	localparam int DATA_W        = 64;
	localparam int FUNC_W        = 3;
	localparam int IDX_W         = 7;
	localparam int STAT_W        = 2;

	// Operation codes carried in the func field.
	localparam logic [FUNC_W-1:0] F_APPEND  = 3'd0;
	localparam logic [FUNC_W-1:0] F_PREPEND = 3'd1;
	localparam logic [FUNC_W-1:0] F_INSERT  = 3'd2;
	localparam logic [FUNC_W-1:0] F_READ    = 3'd3;
	localparam logic [FUNC_W-1:0] F_REMOVE  = 3'd4;
	localparam logic [FUNC_W-1:0] F_FAST    = 3'd5;
	localparam logic [FUNC_W-1:0] F_CLEAR   = 3'd6;
	// Spare code: does nothing and reports ok.
	localparam logic [FUNC_W-1:0] F_NOP     = 3'd7;

	// Status codes.
	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_OOB  = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [IDX_W-1:0]  index;
		logic [DATA_W-1:0] value;
	} ilt_req_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_value;
		logic [STAT_W-1:0] status;
		logic [IDX_W-1:0]  count;
	} ilt_rsp_t;

	// Action broadcast to every cell of the row.
	typedef enum logic [1:0] {
		ACT_HOLD,
		ACT_INS,
		ACT_DEL,
		ACT_FILL
	} ilt_act_t;

	typedef struct packed {
		ilt_act_t          act;
		logic [DATA_W-1:0] value;
	} ilt_cell_ctrl_t;

	// Number of radix-4 levels needed to reduce depth leaves to one node.
	function automatic int ilt_tree_levels(input int depth);
		int n;
		int l;
		n = 1;
		l = 0;
		for (int i = 0; i < 8; i++) begin
			if (n < depth) begin
				n = n * 4;
				l = l + 1;
			end
		end
		if (l < 1) begin
			l = 1;
		end
		return l;
	endfunction

endpackage

[rtl/core/indexed_list_table.sv]
// Channel    Direction  Handshake                 Payload
// command    in         start high, busy low      cmd  (ilt_req_t)
// result     out        done high for one cycle   rsp  (ilt_rsp_t)
//
// Append, prepend, insert, remove, clear and every rejected command leave
// busy low: the result appears the cycle after the transfer, because the
// whole row of cells shifts at the clock edge that takes the command.
// Read and fast remove pass through the registered levels of the radix-4
// gather tree: busy is high while the gather is in flight, and the result follows.
// Reset clears the entry count and the control state; stored entries keep their contents.
// The receiver cannot stall; each result stays on rsp until the next result replaces it.
module indexed_list_table import ilt_pkg::*; #(
	parameter int DEPTH = ILT_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  ilt_req_t cmd,
	output logic     busy,
	output logic     done,
	output ilt_rsp_t rsp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > IDX_W) ? CW : IDX_W;

	typedef enum logic {
		S_IDLE,
		S_GATHER
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic              fast_q;
	logic              done_q;
	logic [IDX_W-1:0]  idx_q;
	ilt_rsp_t          rsp_q;

	logic              accept;
	logic              launch;
	logic [XW-1:0]     cnt_x;
	logic [XW-1:0]     idx_x;
	logic [XW-1:0]     cnt_n_x;
	logic              full;
	logic              idx_oob;
	logic              ins_oob;
	logic [STAT_W-1:0] st;
	logic [CW-1:0]     count_n;
	logic [CW-1:0]     key;
	logic [CW-1:0]     sel;
	ilt_act_t          act;
	ilt_cell_ctrl_t    ctrl;
	logic              g_vld;
	logic [DATA_W-1:0] g_data;

	logic [DATA_W-1:0] cell_data [DEPTH];
	logic [DATA_W-1:0] lo_d      [DEPTH];
	logic [DATA_W-1:0] hi_d      [DEPTH];
	logic [DATA_W-1:0] taps      [DEPTH];

	assign busy   = (state_q == S_GATHER);
	assign accept = start && !busy;

	assign cnt_x   = XW'(count_q);
	assign idx_x   = XW'(cmd.index);
	assign full    = (cnt_x == XW'(DEPTH));
	assign idx_oob = (idx_x >= cnt_x);
	assign ins_oob = (idx_x > cnt_x);

	// The gather tree selects either the entry to read or, for a fast
	// remove, the last entry that will fill the hole.
	assign sel = (cmd.func == F_FAST) ? (count_q - CW'(1)) : CW'(cmd.index);

	// Decode the command into one action for the row of cells. A fast remove
	// acts on the cells only when the gathered last entry comes back.
	always_comb begin
		st      = ST_OK;
		act     = ACT_HOLD;
		key     = '0;
		count_n = count_q;
		launch  = 1'b0;
		if (accept) begin
			unique case (cmd.func) inside
				F_APPEND: begin
					if (full) begin
						st = ST_FULL;
					end else begin
						act     = ACT_INS;
						key     = count_q;
						count_n = count_q + CW'(1);
					end
				end
				F_PREPEND: begin
					if (full) begin
						st = ST_FULL;
					end else begin
						act     = ACT_INS;
						count_n = count_q + CW'(1);
					end
				end
				F_INSERT: begin
					if (ins_oob) begin
						st = ST_OOB;
					end else if (full) begin
						st = ST_FULL;
					end else begin
						act     = ACT_INS;
						key     = CW'(cmd.index);
						count_n = count_q + CW'(1);
					end
				end
				F_READ, F_FAST: begin
					if (idx_oob) begin
						st = ST_OOB;
					end else begin
						launch = 1'b1;
					end
				end
				F_REMOVE: begin
					if (idx_oob) begin
						st = ST_OOB;
					end else begin
						act     = ACT_DEL;
						key     = CW'(cmd.index);
						count_n = count_q - CW'(1);
					end
				end
				F_CLEAR: begin
					count_n = '0;
				end
				default: begin
				end
			endcase
		end else if (busy && g_vld && fast_q) begin
			act     = ACT_FILL;
			key     = CW'(idx_q);
			count_n = count_q - CW'(1);
		end
	end

	assign cnt_n_x    = XW'(count_n);
	assign ctrl.act   = act;
	assign ctrl.value = busy ? g_data : cmd.value;

	// The row of cells: each holds one entry and trades with its neighbors.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_bottom
			assign lo_d[i] = cell_data[i];
		end else begin : g_lo
			assign lo_d[i] = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_top
			assign hi_d[i] = cell_data[i];
		end else begin : g_hi
			assign hi_d[i] = cell_data[i+1];
		end

		ilt_cell #(
			.DEPTH (DEPTH),
			.POS   (i)
		) u_cell (
			.clk  (clk),
			.ctrl (ctrl),
			.key  (key),
			.sel  (sel),
			.lo   (lo_d[i]),
			.hi   (hi_d[i]),
			.data (cell_data[i]),
			.tap  (taps[i])
		);
	end

	ilt_gather #(
		.DEPTH (DEPTH)
	) u_gather (
		.clk    (clk),
		.arst_n (arst_n),
		.launch (launch),
		.taps   (taps),
		.data   (g_data),
		.vld    (g_vld)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			fast_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_n;
			done_q  <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (launch) begin
							state_q <= S_GATHER;
							fast_q  <= (cmd.func == F_FAST);
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				S_GATHER: begin
					if (g_vld) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result payload and the hole index of a pending fast remove.
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q <= cmd.index;
		end
		if (accept && !launch) begin
			rsp_q.read_value <= '0;
			rsp_q.status     <= st;
			rsp_q.count      <= cnt_n_x[IDX_W-1:0];
		end else if (busy && g_vld) begin
			rsp_q.read_value <= fast_q ? '0 : g_data;
			rsp_q.status     <= ST_OK;
			rsp_q.count      <= cnt_n_x[IDX_W-1:0];
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	// The count never passes the capacity of the row.
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above capacity");

	// A command that does not use the gather tree reports its result in the next cycle.
	a_quick_done: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !launch) |=> done)
		else $error("missing result after single-cycle command");

	// A rejected command leaves the count as it was.
	a_err_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != ST_OK) |-> (count_q == $past(count_q)))
		else $error("count changed on rejected command");

	// A gather in flight blocks new commands and its result ends the wait.
	a_gather_done: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && g_vld) |=> (done && !busy))
		else $error("gather result not reported");

endmodule

[rtl/core/ilt_cell.sv]
module ilt_cell import ilt_pkg::*; #(
	parameter int DEPTH = ILT_DEPTH_DEF,
	parameter int POS   = 0
) (
	input  logic                         clk,
	input  ilt_cell_ctrl_t               ctrl,
	input  logic [$clog2(DEPTH+1)-1:0]   key,
	input  logic [$clog2(DEPTH+1)-1:0]   sel,
	input  logic [DATA_W-1:0]            lo,
	input  logic [DATA_W-1:0]            hi,
	output logic [DATA_W-1:0]            data,
	output logic [DATA_W-1:0]            tap
);

	localparam int CW = $clog2(DEPTH+1);
	localparam logic [CW-1:0] POS_K = CW'(POS);

	logic [DATA_W-1:0] data_q;

	// Insert moves entries at and above the key up by one; remove pulls
	// the entries above the key down by one.
	always_ff @(posedge clk) begin
		case (ctrl.act)
			ACT_INS: begin
				if (POS_K > key) begin
					data_q <= lo;
				end else if (POS_K == key) begin
					data_q <= ctrl.value;
				end
			end
			ACT_DEL: begin
				if (POS_K >= key) begin
					data_q <= hi;
				end
			end
			ACT_FILL: begin
				if (POS_K == key) begin
					data_q <= ctrl.value;
				end
			end
			default: begin
			end
		endcase
	end

	assign data = data_q;
	assign tap  = (POS_K == sel) ? data_q : '0;

endmodule

[rtl/core/ilt_gather.sv]
module ilt_gather import ilt_pkg::*; #(
	parameter int DEPTH = ILT_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              launch,
	input  logic [DATA_W-1:0] taps [DEPTH],
	output logic [DATA_W-1:0] data,
	output logic              vld
);

	localparam int LEVELS = ilt_tree_levels(DEPTH);
	localparam int LEAVES = 1 << (2 * LEVELS);
	localparam int QUART  = LEAVES / 4;

	logic [DATA_W-1:0] leaf    [LEAVES];
	logic [DATA_W-1:0] stage_q [LEVELS][LEAVES];
	logic [LEVELS-1:0] vld_q;

	for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
		if (j < DEPTH) begin : g_used
			assign leaf[j] = taps[j];
		end else begin : g_pad
			assign leaf[j] = '0;
		end
	end

	// At most one tap is nonzero, so an OR tree selects it.
	for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
		if (l == 0) begin : g_first
			always_ff @(posedge clk) begin
				for (int j = 0; j < LEAVES; j++) begin
					if (j < QUART) begin
						stage_q[l][j] <= leaf[4*j] | leaf[4*j+1] |
							leaf[4*j+2] | leaf[4*j+3];
					end else begin
						stage_q[l][j] <= '0;
					end
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				for (int j = 0; j < LEAVES; j++) begin
					if (j < QUART) begin
						stage_q[l][j] <= stage_q[l-1][4*j] | stage_q[l-1][4*j+1] |
							stage_q[l-1][4*j+2] | stage_q[l-1][4*j+3];
					end else begin
						stage_q[l][j] <= '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= LEVELS'({vld_q, launch});
		end
	end

	assign data = stage_q[LEVELS-1][0];
	assign vld  = vld_q[LEVELS-1];

endmodule
